>>> hw/rtl/caf_pkg.sv
// ----------------------------------------------------------------------------
// caf_pkg: shared types and constants of the acceptance filter
// Field widths, table depth, command codes and the entry and result records.
// ----------------------------------------------------------------------------
package caf_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int ID_W     = 29;
  localparam int DATA_W   = 64;
  localparam int HANDLE_W = 31;

  localparam logic [ID_W-1:0] BUCKET_RESET = 29'h3FFFF00;

  // command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  // one stored filter entry
  typedef struct packed {
    logic [ID_W-1:0]   id_mask;
    logic [ID_W-1:0]   id_match;
    logic [DATA_W-1:0] data_mask;
    logic [DATA_W-1:0] data_match;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one result record
  typedef struct packed {
    logic                accepted;
    logic [HANDLE_W-1:0] handle;
    logic                table_full;
  } res_t;

endpackage

>>> hw/rtl/can_mask_match_acceptance_filter_unit.sv
// ----------------------------------------------------------------------------
// can_mask_match_acceptance_filter_unit: CAN mask-match acceptance filter
// Table of identifier/payload filter entries held in a RAM; add and frame
// commands, one result per command, with a skid stage ahead of the output.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    cmd, frame_id, payload, masks
//  out      output     out_valid / out_ready  accepted, handle, table_full
//  cfg      input      cfg_valid / cfg_ready  bucket_mask
//
//  An add command, or a frame command on an empty table, forms its result
//  straight from the command, and the result then moves out through the
//  skid stage. A frame command on a filled table first scans the entries
//  one at a time up to the first hit or the last filled entry, since the
//  entry RAM has a single read port.
//  Reset empties the table by zeroing the fill count; no clearing pass.
//  A new command is taken once the previous result has left the skid stage;
//  a stalled output holds its result while the next command is worked on.
// ----------------------------------------------------------------------------
module can_mask_match_acceptance_filter_unit
  import caf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [ID_W-1:0]     in_frame_id,
  input  logic [DATA_W-1:0]   in_payload,
  input  logic [ID_W-1:0]     in_id_mask,
  input  logic [ID_W-1:0]     in_id_match,
  input  logic [DATA_W-1:0]   in_data_mask,
  input  logic [DATA_W-1:0]   in_data_match,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_accepted,
  output logic [HANDLE_W-1:0] out_handle,
  output logic                out_table_full,
  // configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ID_W-1:0]     cfg_bucket_mask
);

  logic [ID_W-1:0] bucket_r;
  logic            pend_r;
  res_t            pend_data_r;
  logic            out_valid_r;
  res_t            out_data_r;
  logic            res_valid;
  res_t            res;
  logic            move;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_r <= BUCKET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bucket_r <= cfg_bucket_mask;
    end
  end

  // table sequencer
  caf_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_frame_id   (in_frame_id),
    .in_payload    (in_payload),
    .in_id_mask    (in_id_mask),
    .in_id_match   (in_id_match),
    .in_data_mask  (in_data_mask),
    .in_data_match (in_data_match),
    .bucket_mask   (bucket_r),
    .slot_free     (!pend_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  // skid stage feeding the output register
  assign move = pend_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_valid) begin
        pend_r <= 1'b1;
      end else if (move) begin
        pend_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      pend_data_r <= res;
    end
    if (move) begin
      out_data_r <= pend_data_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_data_r.accepted;
  assign out_handle     = out_data_r.handle;
  assign out_table_full = out_data_r.table_full;

  // checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !pend_r)
    else $error("result produced while skid stage occupied");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second command taken before first result");

  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_handle == '0 && !out_accepted))
    else $error("full-table result carries handle or accept");

  a_accept_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> (out_handle == '0 && !out_table_full))
    else $error("frame result carries add fields");

endmodule

>>> hw/rtl/caf_entry_ram.sv
// ----------------------------------------------------------------------------
// caf_entry_ram: single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module caf_entry_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/caf_ctrl.sv
// ----------------------------------------------------------------------------
// caf_ctrl: filter table sequencer
// Appends entries to the RAM at the fill count and scans the filled part
// of the RAM one entry per cycle for a frame test, stopping at the first hit.
// ----------------------------------------------------------------------------
module caf_ctrl
  import caf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // command side
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [ID_W-1:0]   in_frame_id,
  input  logic [DATA_W-1:0] in_payload,
  input  logic [ID_W-1:0]   in_id_mask,
  input  logic [ID_W-1:0]   in_id_match,
  input  logic [DATA_W-1:0] in_data_mask,
  input  logic [DATA_W-1:0] in_data_match,
  // grouping register
  input  logic [ID_W-1:0]   bucket_mask,
  // result side
  input  logic              slot_free,
  output logic              res_valid,
  output res_t              res
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                st_r, st_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [IDX_W-1:0]    idx_r;
  logic [ID_W-1:0]     fid_r;
  logic [DATA_W-1:0]   pl_r;

  logic                acc;
  logic                is_full;
  logic                last;
  logic                hit;
  logic [HANDLE_W-1:0] handle_inc;
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  entry_t              wentry, rentry;

  assign in_ready = (st_r == ST_IDLE) && slot_free;
  assign acc      = in_valid && in_ready;
  assign is_full  = (cnt_r == CNT_W'(MAX_ENTRIES));
  assign last     = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);

  // saturating handle
  assign handle_inc = (handle_r == '1) ? handle_r : handle_r + HANDLE_W'(1);

  // entry RAM
  assign wentry.id_mask    = in_id_mask;
  assign wentry.id_match   = in_id_match;
  assign wentry.data_mask  = in_data_mask;
  assign wentry.data_match = in_data_match;

  assign ram_we    = acc && (in_cmd == CMD_ADD) && !is_full;
  assign ram_re    = (acc && (in_cmd == CMD_FRAME)) || ((st_r == ST_SCAN) && !last);
  assign ram_raddr = (st_r == ST_IDLE) ? '0 : idx_r + IDX_W'(1);

  caf_entry_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (wentry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rentry)
  );

  // three tests against the entry read last cycle
  assign hit = ((rentry.id_match & bucket_mask) == (fid_r & bucket_mask))
            && ((rentry.id_mask & fid_r) == rentry.id_match)
            && ((rentry.data_mask & pl_r) == rentry.data_match);

  // sequencer and result
  always_comb begin
    st_nxt    = st_r;
    res_valid = 1'b0;
    res       = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_cmd == CMD_ADD) begin
            res_valid      = 1'b1;
            res.table_full = is_full;
            res.handle     = is_full ? '0 : handle_inc;
          end else if (cnt_r == '0) begin
            res_valid = 1'b1;
          end else begin
            st_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit || last) begin
          res_valid    = 1'b1;
          res.accepted = hit;
          st_nxt       = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      cnt_r    <= '0;
      handle_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (ram_we) begin
        cnt_r    <= cnt_r + CNT_W'(1);
        handle_r <= handle_inc;
      end
    end
  end

  // frame capture and scan index
  always_ff @(posedge clk) begin
    if (acc) begin
      fid_r <= in_frame_id;
      pl_r  <= in_payload;
      idx_r <= '0;
    end else if (st_r == ST_SCAN) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

endmodule
